>>> hdl/tvfs_pkg.sv
// Shared widths, codes, vector type and lerp helper for the trilinear vector field sampler.
package tvfs_pkg;

    localparam int FracBits   = 8;
    localparam int CompWidth  = 16;
    localparam int PosWidth   = 14;
    localparam int SizeWidth  = 6;
    localparam int IdxWidth   = 15;
    localparam int CoordWidth = PosWidth - 1 - FracBits;
    localparam int CfgIdxWidth = 2;

    localparam logic [SizeWidth-1:0] SizeReset = SizeWidth'(32);

    // Configuration register indexes
    localparam logic [CfgIdxWidth-1:0] REG_SIZE_X = 2'd0;
    localparam logic [CfgIdxWidth-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [CfgIdxWidth-1:0] REG_SIZE_Z = 2'd2;

    // Request kinds
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef logic signed [CompWidth-1:0] comp_t;
    typedef logic [FracBits-1:0]         frac_t;

    typedef struct packed {
        comp_t x;
        comp_t y;
        comp_t z;
    } vec_t;

    // a + floor((b - a) * f / 2^FracBits); equals (a*(2^F - f) + b*f) >> F
    function automatic comp_t lerp1(input comp_t a, input comp_t b, input frac_t f);
        logic signed [CompWidth:0]                d;
        logic signed [FracBits:0]                 fs;
        logic signed [CompWidth+FracBits+1:0]     p;
        logic signed [CompWidth+1:0]              s;
        d  = (CompWidth+1)'(b) - (CompWidth+1)'(a);
        fs = $signed({1'b0, f});
        p  = d * fs;
        s  = (CompWidth+2)'(a) + p[CompWidth+FracBits+1:FracBits];
        return s[CompWidth-1:0];
    endfunction

    function automatic vec_t lerp3(input vec_t a, input vec_t b, input frac_t f);
        vec_t r;
        r.x = lerp1(a.x, b.x, f);
        r.y = lerp1(a.y, b.y, f);
        r.z = lerp1(a.z, b.z, f);
        return r;
    endfunction

endpackage

>>> hdl/tvfs_req_if.sv
// Request channel: load and query beats into the sampler.
interface tvfs_req_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  req_type;
    logic [tvfs_pkg::IdxWidth-1:0]         voxel_index;
    logic signed [tvfs_pkg::CompWidth-1:0] comp_x;
    logic signed [tvfs_pkg::CompWidth-1:0] comp_y;
    logic signed [tvfs_pkg::CompWidth-1:0] comp_z;
    logic signed [tvfs_pkg::PosWidth-1:0]  pos_x;
    logic signed [tvfs_pkg::PosWidth-1:0]  pos_y;
    logic signed [tvfs_pkg::PosWidth-1:0]  pos_z;

    modport source (
        output valid, req_type, voxel_index, comp_x, comp_y, comp_z, pos_x, pos_y, pos_z,
        input  ready
    );
    modport sink (
        input  valid, req_type, voxel_index, comp_x, comp_y, comp_z, pos_x, pos_y, pos_z,
        output ready
    );
endinterface

>>> hdl/tvfs_res_if.sv
// Result channel: interpolated vector beats out of the sampler.
interface tvfs_res_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [tvfs_pkg::CompWidth-1:0] out_x;
    logic signed [tvfs_pkg::CompWidth-1:0] out_y;
    logic signed [tvfs_pkg::CompWidth-1:0] out_z;
    logic                                  in_range;

    modport source (
        output valid, out_x, out_y, out_z, in_range,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_z, in_range,
        output ready
    );
endinterface

>>> hdl/trilinear_vector_field_sampler.sv
// Trilinear vector field sampler: grid store, address sequencer and shared lerp unit.
//
// The block holds a 32768-entry grid of signed Q8.8 vectors in one single-port
// memory and answers position queries by trilinear interpolation (z, then y,
// then x). A load beat writes one grid entry and returns no result; the block
// stays ready. A query beat first range-checks the position and forms the size
// products, then forms the base address, then reads the eight neighbours
// through the one memory port (the z-lerps run on the shared lerp unit as
// pairs come back), then drains the last read and runs the y/x lerps, after
// which the result is moved into the output register. A query outside the
// grid on any axis skips the reads and returns a zero vector with in_range
// low. The memory read port sets the bulk of the query time. The output
// register lets the next beat be accepted while a result still waits to be
// taken. Grid entries carry no reset; only loaded entries may be sampled.
// Sizes are set through the write port (index 0/1/2 = x/y/z); the user is to
// write them only while idle, which the block itself does not enforce.
module trilinear_vector_field_sampler (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tvfs_pkg::CfgIdxWidth-1:0]   cfg_index,
    input  logic [tvfs_pkg::SizeWidth-1:0]     cfg_data,
    tvfs_req_if.sink                           req,
    tvfs_res_if.source                         res
);

    localparam int SW = tvfs_pkg::SizeWidth;
    localparam int CW = tvfs_pkg::CoordWidth;
    localparam int IW = tvfs_pkg::IdxWidth;
    localparam int FB = tvfs_pkg::FracBits;
    localparam int PW = tvfs_pkg::PosWidth;
    localparam int Depth = 1 << IW;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_BASE  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_YX    = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // ---------------- configuration ----------------
    logic [SW-1:0] size_x_reg, size_y_reg, size_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= tvfs_pkg::SizeReset;
            size_y_reg <= tvfs_pkg::SizeReset;
            size_z_reg <= tvfs_pkg::SizeReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tvfs_pkg::REG_SIZE_X: size_x_reg <= cfg_data;
                tvfs_pkg::REG_SIZE_Y: size_y_reg <= cfg_data;
                tvfs_pkg::REG_SIZE_Z: size_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- control and datapath registers ----------------
    logic [2:0]            state_reg, state_next;
    logic [2:0]            cnt_reg, cnt_next;
    logic                  rd_valid_reg;
    logic [2:0]            rd_k_reg;
    logic                  out_valid_reg;

    logic [PW-1:0]         pos_x_reg, pos_y_reg, pos_z_reg;
    logic [CW-1:0]         x0_reg, y0_reg, z0_reg;
    logic                  dx_reg, dy_reg, dz_reg;
    tvfs_pkg::frac_t       fx_reg, fy_reg, fz_reg;
    logic [2*SW-1:0]       sxy_reg;
    logic [CW+SW-1:0]      ysx_reg;
    logic [IW-1:0]         base_reg;

    tvfs_pkg::vec_t        rdata_reg;
    tvfs_pkg::vec_t        hold_reg;
    tvfs_pkg::vec_t        zl_reg [4];
    tvfs_pkg::vec_t        wl_reg [2];
    tvfs_pkg::vec_t        acc_reg;
    logic                  acc_inr_reg;
    tvfs_pkg::vec_t        out_vec_reg;
    logic                  out_inr_reg;

    // ---------------- grid memory ----------------
    tvfs_pkg::vec_t        mem [Depth];
    logic                  mem_we;
    logic [IW-1:0]         mem_addr;
    logic [IW-1:0]         rd_addr;
    tvfs_pkg::vec_t        load_vec;

    assign load_vec.x = req.comp_x;
    assign load_vec.y = req.comp_y;
    assign load_vec.z = req.comp_z;

    logic req_fire;
    assign req_fire = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);

    assign mem_we   = req_fire && (req.req_type == tvfs_pkg::REQ_LOAD);
    assign mem_addr = (state_reg == S_IDLE) ? req.voxel_index : rd_addr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= load_vec;
        end
        else
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    // neighbour k: bit0 selects z1, bit1 y1, bit2 x1
    always_comb
    begin
        rd_addr = base_reg
                + ((cnt_reg[0] && dz_reg) ? IW'(sxy_reg) : '0)
                + ((cnt_reg[1] && dy_reg) ? IW'(size_x_reg) : '0)
                + ((cnt_reg[2] && dx_reg) ? IW'(1) : '0);
    end

    // ---------------- axis checks ----------------
    // inside when size != 0, pos >= 0 and pos <= (size-1) << FracBits
    logic          x_in, y_in, z_in;
    logic [CW-1:0] x_lo, y_lo, z_lo;
    logic          x_up, y_up, z_up;

    always_comb
    begin
        x_in = (size_x_reg != '0) && !pos_x_reg[PW-1]
            && ({1'b0, pos_x_reg[PW-2:0]} <= {SW'(size_x_reg - SW'(1)), FB'(0)});
        y_in = (size_y_reg != '0) && !pos_y_reg[PW-1]
            && ({1'b0, pos_y_reg[PW-2:0]} <= {SW'(size_y_reg - SW'(1)), FB'(0)});
        z_in = (size_z_reg != '0) && !pos_z_reg[PW-1]
            && ({1'b0, pos_z_reg[PW-2:0]} <= {SW'(size_z_reg - SW'(1)), FB'(0)});
        x_lo = pos_x_reg[PW-2:FB];
        y_lo = pos_y_reg[PW-2:FB];
        z_lo = pos_z_reg[PW-2:FB];
        // upper neighbour clamps to size-1 at the top edge
        x_up = SW'(x_lo) < SW'(size_x_reg - SW'(1));
        y_up = SW'(y_lo) < SW'(size_y_reg - SW'(1));
        z_up = SW'(z_lo) < SW'(size_z_reg - SW'(1));
    end

    // ---------------- shared lerp unit ----------------
    tvfs_pkg::vec_t  lerp_a, lerp_b, lerp_r;
    tvfs_pkg::frac_t lerp_f;

    always_comb
    begin
        lerp_a = hold_reg;
        lerp_b = rdata_reg;
        lerp_f = fz_reg;
        if (!rd_valid_reg)
        begin
            case (cnt_reg)
                3'd1:
                begin
                    lerp_a = zl_reg[0];
                    lerp_b = zl_reg[1];
                    lerp_f = fy_reg;
                end
                3'd2:
                begin
                    lerp_a = zl_reg[2];
                    lerp_b = zl_reg[3];
                    lerp_f = fy_reg;
                end
                default:
                begin
                    lerp_a = wl_reg[0];
                    lerp_b = wl_reg[1];
                    lerp_f = fx_reg;
                end
            endcase
        end
        lerp_r = tvfs_pkg::lerp3(lerp_a, lerp_b, lerp_f);
    end

    // ---------------- sequencer ----------------
    logic res_fire;
    assign res_fire = res.valid && res.ready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire && (req.req_type == tvfs_pkg::REQ_QUERY))
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                state_next = (x_in && y_in && z_in) ? S_BASE : S_DONE;
            end
            S_BASE:
            begin
                state_next = S_READ;
                cnt_next   = '0;
            end
            S_READ:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                begin
                    state_next = S_YX;
                end
            end
            S_YX:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd3)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || res_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            rd_k_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            rd_valid_reg <= (state_reg == S_READ);
            rd_k_reg     <= cnt_reg;
            if ((state_reg == S_DONE) && (!out_valid_reg || res_fire))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            pos_x_reg <= req.pos_x;
            pos_y_reg <= req.pos_y;
            pos_z_reg <= req.pos_z;
        end

        if (state_reg == S_SETUP)
        begin
            x0_reg      <= x_lo;
            y0_reg      <= y_lo;
            z0_reg      <= z_lo;
            dx_reg      <= x_up;
            dy_reg      <= y_up;
            dz_reg      <= z_up;
            fx_reg      <= pos_x_reg[FB-1:0];
            fy_reg      <= pos_y_reg[FB-1:0];
            fz_reg      <= pos_z_reg[FB-1:0];
            sxy_reg     <= (2*SW)'(size_x_reg) * (2*SW)'(size_y_reg);
            ysx_reg     <= (CW+SW)'(y_lo) * (CW+SW)'(size_x_reg);
            acc_reg     <= '0;
            acc_inr_reg <= x_in && y_in && z_in;
        end

        if (state_reg == S_BASE)
        begin
            // linear index wraps modulo the store depth
            base_reg <= IW'(x0_reg) + IW'(ysx_reg) + IW'(z0_reg) * IW'(sxy_reg);
        end

        if (rd_valid_reg)
        begin
            if (!rd_k_reg[0])
            begin
                hold_reg <= rdata_reg;
            end
            else
            begin
                zl_reg[rd_k_reg[2:1]] <= lerp_r;
            end
        end
        else if (state_reg == S_YX)
        begin
            case (cnt_reg)
                3'd1:    wl_reg[0] <= lerp_r;
                3'd2:    wl_reg[1] <= lerp_r;
                3'd3:    acc_reg   <= lerp_r;
                default: ;
            endcase
        end

        if ((state_reg == S_DONE) && (!out_valid_reg || res_fire))
        begin
            out_vec_reg <= acc_reg;
            out_inr_reg <= acc_inr_reg;
        end
    end

    assign res.valid    = out_valid_reg;
    assign res.out_x    = out_vec_reg.x;
    assign res.out_y    = out_vec_reg.y;
    assign res.out_z    = out_vec_reg.z;
    assign res.in_range = out_inr_reg;

endmodule

>>> bench/trilinear_vector_field_sampler_test.sv
// Self-checking bench for the trilinear vector field sampler: random loads and queries.
`timescale 1ns / 100ps

typedef struct packed {
    tvfs_pkg::vec_t v;
    logic           hit;
} field_sample_t;

// Shadow of the grid and size registers; predicts each query and checks result beats.
class field_mirror;
    tvfs_pkg::comp_t grid[3][1 << tvfs_pkg::IdxWidth];
    int unsigned     dim[3];
    field_sample_t   pending[$];
    int              errors;

    function new();
        dim    = '{32, 32, 32};
        errors = 0;
    endfunction

    function void set_size(input logic [tvfs_pkg::CfgIdxWidth-1:0] index,
                           input logic [tvfs_pkg::SizeWidth-1:0] value);
        case (index)
            tvfs_pkg::REG_SIZE_X: dim[0] = value;
            tvfs_pkg::REG_SIZE_Y: dim[1] = value;
            tvfs_pkg::REG_SIZE_Z: dim[2] = value;
            default: ;
        endcase
    endfunction

    function int unsigned voxel_addr(input int unsigned x, y, z);
        return (x + y * dim[0] + z * dim[0] * dim[1]) % (1 << tvfs_pkg::IdxWidth);
    endfunction

    // Lower/upper neighbor and fraction on one axis; 0 when outside the grid.
    function bit locate(input logic signed [tvfs_pkg::PosWidth-1:0] p,
                        input int unsigned size,
                        output int unsigned lo, output int unsigned hi,
                        output int unsigned fr);
        int pos;
        pos = p;
        lo  = 0;
        hi  = 0;
        fr  = 0;
        if (size == 0 || pos < 0 || pos > ((int'(size) - 1) <<< tvfs_pkg::FracBits))
            return 0;
        lo = pos >>> tvfs_pkg::FracBits;
        hi = (lo + 1 > size - 1) ? size - 1 : lo + 1;
        fr = pos & ((1 << tvfs_pkg::FracBits) - 1);
        return 1;
    endfunction

    // floor((a*(1 - f) + b*f)) in Q.FracBits
    function longint blend(input longint a, input longint b, input int unsigned f);
        longint w;
        w = f;
        return (a * ((longint'(1) <<< tvfs_pkg::FracBits) - w) + b * w)
               >>> tvfs_pkg::FracBits;
    endfunction

    function longint along_z(input int c, input int unsigned x, y, z0, z1, f);
        return blend(grid[c][voxel_addr(x, y, z0)], grid[c][voxel_addr(x, y, z1)], f);
    endfunction

    function field_sample_t interpolate(input logic signed [tvfs_pkg::PosWidth-1:0] px,
                                        py, pz);
        int unsigned     lo[3];
        int unsigned     hi[3];
        int unsigned     fr[3];
        longint          i1, i2, j1, j2, w1, w2;
        tvfs_pkg::comp_t part[3];
        field_sample_t   s;
        s = '0;
        if (!(locate(px, dim[0], lo[0], hi[0], fr[0]) &&
              locate(py, dim[1], lo[1], hi[1], fr[1]) &&
              locate(pz, dim[2], lo[2], hi[2], fr[2])))
            return s;
        for (int c = 0; c < 3; c++) begin
            i1 = along_z(c, lo[0], lo[1], lo[2], hi[2], fr[2]);
            i2 = along_z(c, lo[0], hi[1], lo[2], hi[2], fr[2]);
            j1 = along_z(c, hi[0], lo[1], lo[2], hi[2], fr[2]);
            j2 = along_z(c, hi[0], hi[1], lo[2], hi[2], fr[2]);
            w1 = blend(i1, i2, fr[1]);
            w2 = blend(j1, j2, fr[1]);
            part[c] = tvfs_pkg::comp_t'(blend(w1, w2, fr[0]));
        end
        s.v.x = part[0];
        s.v.y = part[1];
        s.v.z = part[2];
        s.hit = 1'b1;
        return s;
    endfunction

    function void note_beat(input logic kind, input logic [tvfs_pkg::IdxWidth-1:0] idx,
                            input tvfs_pkg::vec_t load,
                            input logic signed [tvfs_pkg::PosWidth-1:0] px, py, pz);
        if (kind == tvfs_pkg::REQ_LOAD) begin
            grid[0][idx] = load.x;
            grid[1][idx] = load.y;
            grid[2][idx] = load.z;
        end else begin
            pending.push_back(interpolate(px, py, pz));
        end
    endfunction

    function void compare(input string name,
                          input logic signed [tvfs_pkg::CompWidth:0] want, got);
        if (got !== want) begin
            errors++;
            if (errors <= 50)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    function void check_sample(input tvfs_pkg::comp_t gx, gy, gz, input logic ghit);
        field_sample_t want;
        if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat, expected none, actual %0d %0d %0d %0b",
                     $time, gx, gy, gz, ghit);
            return;
        end
        want = pending.pop_front();
        compare("out_x", want.v.x, gx);
        compare("out_y", want.v.y, gy);
        compare("out_z", want.v.z, gz);
        compare("in_range", want.hit, ghit);
    endfunction
endclass

module trilinear_vector_field_sampler_test;

    // Index 3 has no register behind it; writes there must change nothing.
    localparam logic [tvfs_pkg::CfgIdxWidth-1:0] RegUnused = 2'd3;
    localparam int CycleLimit  = 1000000;
    localparam int PhaseBeats  = 75;
    localparam int SettleCycles = 20;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [tvfs_pkg::CfgIdxWidth-1:0] cfg_index;
    logic [tvfs_pkg::SizeWidth-1:0]   cfg_data;

    tvfs_req_if req();
    tvfs_res_if res();

    trilinear_vector_field_sampler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .res       (res)
    );

    field_mirror mirror;

    // Grid entries the stimulus has already loaded; queries only touch these.
    bit loaded[1 << tvfs_pkg::IdxWidth];

    int req_calm;
    int res_calm;
    int cycle_count;

    // Size plan per phase; 0 picks a random small size.
    int plan[10][3] = '{'{1, 1, 1}, '{2, 2, 2}, '{32, 1, 1}, '{1, 32, 1}, '{1, 1, 32},
                        '{3, 5, 2}, '{4, 1, 6}, '{0, 0, 0}, '{0, 0, 0}, '{32, 32, 32}};

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gap length for either side: mostly none or short, a few long, and
    // now and then a calm stretch with no idling at all.
    function automatic int draw_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Components lean on the Q8.8 extremes.
    function automatic tvfs_pkg::comp_t pick_comp();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return tvfs_pkg::comp_t'(16'h7FFF);
        if (r < 16)
            return tvfs_pkg::comp_t'(16'h8000);
        if (r < 20)
            return '0;
        return tvfs_pkg::comp_t'($urandom);
    endfunction

    function automatic tvfs_pkg::vec_t pick_vec();
        tvfs_pkg::vec_t v;
        v.x = pick_comp();
        v.y = pick_comp();
        v.z = pick_comp();
        return v;
    endfunction

    // Position on one axis: mostly inside, with the upper edge, grid points,
    // fraction 255, negatives and overshoots weighted in.
    function automatic logic signed [tvfs_pkg::PosWidth-1:0] pick_pos(input int unsigned size);
        int top;
        int r;
        int v;
        top = (int'(size) - 1) << tvfs_pkg::FracBits;
        r   = $urandom_range(0, 99);
        if (r < 10)
            v = top;
        else if (r < 20)
            v = $urandom_range(0, size - 1) << tvfs_pkg::FracBits;
        else if (r < 27)
            v = ($urandom_range(0, size - 1) << tvfs_pkg::FracBits)
              | ((1 << tvfs_pkg::FracBits) - 1);
        else if (r < 85)
            v = $urandom_range(0, top);
        else if (r < 93)
            v = -$urandom_range(1, 8192);
        else
            v = $urandom_range(top + 1, 8191);
        return tvfs_pkg::PosWidth'(v);
    endfunction

    // One request beat. valid stays high after acceptance so that a
    // back-to-back beat is a single assignment in the next call's step.
    task automatic send_beat(input logic kind, input logic [tvfs_pkg::IdxWidth-1:0] idx,
                             input tvfs_pkg::vec_t v,
                             input logic signed [tvfs_pkg::PosWidth-1:0] px, py, pz);
        int gap;
        gap = draw_gap(req_calm);
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.req_type    <= kind;
        req.voxel_index <= idx;
        req.comp_x      <= v.x;
        req.comp_y      <= v.y;
        req.comp_z      <= v.z;
        req.pos_x       <= px;
        req.pos_y       <= py;
        req.pos_z       <= pz;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    task automatic send_load(input logic [tvfs_pkg::IdxWidth-1:0] idx,
                             input tvfs_pkg::vec_t v);
        loaded[idx] = 1'b1;
        send_beat(tvfs_pkg::REQ_LOAD, idx, v, tvfs_pkg::PosWidth'($urandom),
                  tvfs_pkg::PosWidth'($urandom), tvfs_pkg::PosWidth'($urandom));
    endtask

    // A query inside the grid is preceded by loads of any of its eight
    // neighbors not yet written, so no unwritten entry is ever read.
    task automatic run_query(input logic signed [tvfs_pkg::PosWidth-1:0] px, py, pz);
        int unsigned lo[3];
        int unsigned hi[3];
        int unsigned fr[3];
        int unsigned addr;
        bit hit;
        int k;
        hit = mirror.locate(px, mirror.dim[0], lo[0], hi[0], fr[0]) &&
              mirror.locate(py, mirror.dim[1], lo[1], hi[1], fr[1]) &&
              mirror.locate(pz, mirror.dim[2], lo[2], hi[2], fr[2]);
        if (hit) begin
            for (k = 0; k < 8; k++) begin
                addr = mirror.voxel_addr(k[0] ? hi[0] : lo[0], k[1] ? hi[1] : lo[1],
                                         k[2] ? hi[2] : lo[2]);
                if (!loaded[addr])
                    send_load(tvfs_pkg::IdxWidth'(addr), pick_vec());
            end
        end
        send_beat(tvfs_pkg::REQ_QUERY, tvfs_pkg::IdxWidth'($urandom), pick_vec(), px, py, pz);
    endtask

    // Drop valid, let the last accepted beat reach the predictor, drain
    // every outstanding query, then give the block time to finish a
    // trailing load before anything else happens.
    task automatic settle();
        req.valid <= 1'b0;
        @(posedge clk);
        while (mirror.pending.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic put_reg(input logic [tvfs_pkg::CfgIdxWidth-1:0] index,
                           input logic [tvfs_pkg::SizeWidth-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        mirror.set_size(index, value);
    endtask

    task automatic configure(input int unsigned sx, sy, sz, input bit poke_unused);
        settle();
        put_reg(tvfs_pkg::REG_SIZE_X, tvfs_pkg::SizeWidth'(sx));
        put_reg(tvfs_pkg::REG_SIZE_Y, tvfs_pkg::SizeWidth'(sy));
        put_reg(tvfs_pkg::REG_SIZE_Z, tvfs_pkg::SizeWidth'(sz));
        if (poke_unused)
            put_reg(RegUnused, tvfs_pkg::SizeWidth'($urandom));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Mix: loads inside the grid, loads anywhere in the store, and queries.
    task automatic random_phase(input int count);
        int n;
        int r;
        for (n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 25)
                send_load(tvfs_pkg::IdxWidth'(
                              mirror.voxel_addr($urandom_range(0, mirror.dim[0] - 1),
                                                $urandom_range(0, mirror.dim[1] - 1),
                                                $urandom_range(0, mirror.dim[2] - 1))),
                          pick_vec());
            else if (r < 32)
                send_load(tvfs_pkg::IdxWidth'($urandom), pick_vec());
            else
                run_query(pick_pos(mirror.dim[0]), pick_pos(mirror.dim[1]),
                          pick_pos(mirror.dim[2]));
        end
    endtask

    // Accepted request beats feed the predictor.
    always @(posedge clk) begin
        if (rst_n && req.valid && req.ready)
            mirror.note_beat(req.req_type, req.voxel_index,
                             '{x: req.comp_x, y: req.comp_y, z: req.comp_z},
                             req.pos_x, req.pos_y, req.pos_z);
    end

    // Accepted result beats are checked against the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && res.valid && res.ready)
            mirror.check_sample(res.out_x, res.out_y, res.out_z, res.in_range);
    end

    // Result side back-pressure.
    initial begin : result_sink
        int hold;
        hold = 0;
        res.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold > 0) begin
                res.ready <= 1'b0;
                hold--;
            end else begin
                res.ready <= 1'b1;
                hold = draw_gap(res_calm);
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CycleLimit) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        int top;
        int p;
        mirror   = new();
        req_calm = 0;
        res_calm = 0;

        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= tvfs_pkg::REG_SIZE_X;
        cfg_data        <= '0;
        req.valid       <= 1'b0;
        req.req_type    <= tvfs_pkg::REQ_LOAD;
        req.voxel_index <= '0;
        req.comp_x      <= '0;
        req.comp_y      <= '0;
        req.comp_z      <= '0;
        req.pos_x       <= '0;
        req.pos_y       <= '0;
        req.pos_z       <= '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on the reset 32x32x32 grid.
        top = 31 << tvfs_pkg::FracBits;
        // Far corner with extreme components; upper edge clamps all neighbors to it.
        send_load(tvfs_pkg::IdxWidth'(32767),
                  '{x: tvfs_pkg::comp_t'(16'h7FFF), y: tvfs_pkg::comp_t'(16'h8000), z: '0});
        run_query(tvfs_pkg::PosWidth'(top), tvfs_pkg::PosWidth'(top),
                  tvfs_pkg::PosWidth'(top));
        // Just outside on each side, and the position field extremes.
        run_query(tvfs_pkg::PosWidth'(-1), '0, '0);
        run_query('0, tvfs_pkg::PosWidth'(top + 1), '0);
        run_query('0, '0, tvfs_pkg::PosWidth'(-8192));
        run_query(tvfs_pkg::PosWidth'(8191), tvfs_pkg::PosWidth'(8191),
                  tvfs_pkg::PosWidth'(8191));
        run_query(tvfs_pkg::PosWidth'(-8192), tvfs_pkg::PosWidth'(-8192),
                  tvfs_pkg::PosWidth'(-8192));
        // Fraction 255 below the edge, then the origin with fraction 0.
        run_query(tvfs_pkg::PosWidth'(top - 1), tvfs_pkg::PosWidth'(top - 1),
                  tvfs_pkg::PosWidth'(top - 1));
        run_query('0, '0, '0);

        // Random phases over a range of grid shapes, extremes included.
        for (p = 0; p < 10; p++) begin
            configure(plan[p][0] != 0 ? plan[p][0] : $urandom_range(1, 7),
                      plan[p][1] != 0 ? plan[p][1] : $urandom_range(1, 7),
                      plan[p][2] != 0 ? plan[p][2] : $urandom_range(1, 7),
                      p == 0 || p == 7);
            random_phase(PhaseBeats);
        end

        settle();
        if (mirror.errors == 0 && mirror.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
